FILE: src/bgp_pkg.sv
package bgp_pkg;

   // request opcodes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_XLATE  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // group types
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_DEV   = 2'd1;
   localparam logic [1:0] KIND_HOST  = 2'd2;
   localparam logic [1:0] KIND_MIX   = 2'd3;

   // response status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_SKIP     = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
   localparam logic [1:0] REG_DEV_BLOCKS  = 2'd1;
   localparam logic [1:0] REG_HOST_BLOCKS = 2'd2;
   localparam logic [1:0] REG_GROUP_COUNT = 2'd3;

   // one queued request transaction
   typedef struct packed {
      logic [1:0]  opcode;
      logic        pass_is_host;
      logic [23:0] block_id;
      logic        block_present;
      logic        block_is_host;
      logic [39:0] order_id;
   } cmd_type;

   // configuration register set
   typedef struct packed {
      logic [16:0] block_size;
      logic [6:0]  dev_blocks;
      logic [6:0]  host_blocks;
      logic [8:0]  group_count;
   } cfg_type;

   // group type after one more block lands in it
   function automatic logic [1:0] next_kind(input logic [1:0] kind, input logic host);
      logic [1:0] nk;
      case (kind)
         KIND_EMPTY: nk = host ? KIND_HOST : KIND_DEV;
         KIND_DEV:   nk = host ? KIND_MIX : KIND_DEV;
         KIND_HOST:  nk = host ? KIND_HOST : KIND_MIX;
         default:    nk = KIND_MIX;
      endcase
      return nk;
   endfunction

endpackage

FILE: src/bgp_ram.sv
module bgp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/bgp_div.sv
module bgp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [39:0] quotient,
   output logic [16:0] remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [39:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] dsr_ff, dsr_in;
   logic [17:0] trial;
   logic        fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[39]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 17'(trial - {1'b0, dsr_ff}) : trial[16:0];
         quo_in = {quo_ff[38:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd39) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/bgp_front.sv
module bgp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic               req_pass_is_host,
   input  logic [23:0]        req_block_id,
   input  logic               req_block_present,
   input  logic               req_block_is_host,
   input  logic [39:0]        req_order_id,
   output logic               q_valid,
   output bgp_pkg::cmd_type   q_cmd,
   input  logic               q_pop
);

   bgp_pkg::cmd_type ent_ff [2];
   bgp_pkg::cmd_type cmd;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic       push;

   // classify the transaction: keep only the fields its opcode uses
   always_comb begin
      cmd        = '0;
      cmd.opcode = req_opcode;
      case (req_opcode)
         bgp_pkg::OP_START: cmd.pass_is_host = req_pass_is_host;
         bgp_pkg::OP_ADD: begin
            cmd.block_id      = req_block_id;
            cmd.block_present = req_block_present;
            cmd.block_is_host = req_block_is_host;
         end
         bgp_pkg::OP_XLATE: cmd.order_id = req_order_id;
         default: cmd.opcode = bgp_pkg::OP_UNUSED;
      endcase
   end

   // two-entry queue toward the back end
   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = ent_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = q_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) begin
         ent_ff[wp_ff] <= cmd;
      end
   end

endmodule

FILE: src/bgp_back.sv
module bgp_back #(
   parameter int MAX_GROUPS = 256,
   parameter int MAX_BLOCKS_PER_GROUP = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  bgp_pkg::cfg_type   cfg,
   input  logic               q_valid,
   input  bgp_pkg::cmd_type   q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [39:0]        rsp_index_id,
   output logic [7:0]         rsp_group_index,
   output logic [1:0]         rsp_group_type,
   output logic [1:0]         rsp_status
);

   localparam int CUR_W  = $clog2(MAX_GROUPS + 1);
   localparam int GA_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int FW     = $clog2(MAX_BLOCKS_PER_GROUP + 1);
   localparam int TDEPTH = MAX_GROUPS * MAX_BLOCKS_PER_GROUP;
   localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ADD_RD  = 4'd1;
   localparam logic [3:0] S_ADD_EX  = 4'd2;
   localparam logic [3:0] S_DIV1    = 4'd3;
   localparam logic [3:0] S_DIV2    = 4'd4;
   localparam logic [3:0] S_XL_CHK  = 4'd5;
   localparam logic [3:0] S_XL_FILL = 4'd6;
   localparam logic [3:0] S_XL_TBL  = 4'd7;
   localparam logic [3:0] S_XL_SUM  = 4'd8;

   logic [3:0]             state_ff, state_in;
   bgp_pkg::cmd_type       cmd_ff, cmd_in;
   logic [CUR_W-1:0]       cur_ff, cur_in;
   logic [FW-1:0]          pc_ff, pc_in;
   logic                   pkind_ff, pkind_in;
   logic [MAX_GROUPS-1:0]  valid_ff, valid_in;
   logic                   mvld_ff;
   logic [16:0]            off_ff, off_in;
   logic [39:0]            grp_ff, grp_in;
   logic [7:0]             slot_ff, slot_in;
   logic [40:0]            prod_ff, prod_in;
   logic                   rvalid_ff, rvalid_in;
   logic [39:0]            rid_ff, rid_in;
   logic [7:0]             rgrp_ff, rgrp_in;
   logic [1:0]             rtype_ff, rtype_in;
   logic [1:0]             rstat_ff, rstat_in;

   logic [GA_W-1:0]        meta_raddr;
   logic [FW+1:0]          meta_rdata, meta_wdata;
   logic                   meta_we;
   logic [TA_W-1:0]        tbl_raddr, tbl_waddr;
   logic [23:0]            tbl_rdata;
   logic                   tbl_we;

   logic                   div_start, div_done;
   logic [39:0]            div_dividend, div_quo;
   logic [16:0]            div_divisor, div_rem;

   logic [FW-1:0]          fill;
   logic [1:0]             kind, nk;
   logic [7:0]             gsum, limit;
   logic                   g_ok, close;

   // group fill and type, with one valid bit per group for reset
   bgp_ram #(.WIDTH(FW + 2), .DEPTH(MAX_GROUPS)) u_meta (
      .clock (clock),
      .we    (meta_we),
      .waddr (cur_ff[GA_W-1:0]),
      .wdata (meta_wdata),
      .raddr (meta_raddr),
      .rdata (meta_rdata)
   );

   // block ids, one row per group
   bgp_ram #(.WIDTH(24), .DEPTH(TDEPTH)) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (cmd_ff.block_id),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   bgp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // decoded view of the stored group entry
   assign fill  = mvld_ff ? meta_rdata[FW+1:2] : '0;
   assign kind  = mvld_ff ? meta_rdata[1:0] : bgp_pkg::KIND_EMPTY;
   assign gsum  = {1'b0, cfg.dev_blocks} + {1'b0, cfg.host_blocks};
   assign g_ok  = cur_ff < CUR_W'(MAX_GROUPS);
   assign nk    = bgp_pkg::next_kind(kind, cmd_ff.block_is_host);
   assign limit = (nk == bgp_pkg::KIND_HOST) ? gsum :
                  (pkind_ff ? {1'b0, cfg.host_blocks} : {1'b0, cfg.dev_blocks});
   assign close = (9'(pc_ff) + 9'd1) >= {1'b0, limit};

   // ram addressing and divider operands
   assign meta_raddr   = (state_ff == S_ADD_RD) ? cur_ff[GA_W-1:0] : grp_ff[GA_W-1:0];
   assign meta_wdata   = {FW'(fill + FW'(1)), nk};
   assign tbl_waddr    = TA_W'(int'(cur_ff) * MAX_BLOCKS_PER_GROUP + int'(fill));
   assign tbl_raddr    = TA_W'(int'(grp_ff[GA_W-1:0]) * MAX_BLOCKS_PER_GROUP + int'(slot_ff));
   assign div_dividend = (state_ff == S_IDLE) ? q_cmd.order_id : div_quo;
   assign div_divisor  = (state_ff == S_IDLE) ? cfg.block_size : 17'(gsum);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cur_in    = cur_ff;
      pc_in     = pc_ff;
      pkind_in  = pkind_ff;
      valid_in  = valid_ff;
      off_in    = off_ff;
      grp_in    = grp_ff;
      slot_in   = slot_ff;
      prod_in   = prod_ff;
      rvalid_in = rvalid_ff;
      rid_in    = rid_ff;
      rgrp_in   = rgrp_ff;
      rtype_in  = rtype_ff;
      rstat_in  = rstat_ff;
      q_pop     = 1'b0;
      meta_we   = 1'b0;
      tbl_we    = 1'b0;
      div_start = 1'b0;

      // response register drains on its own
      if (rvalid_ff && !rsp_stall) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid && !rvalid_ff) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               rid_in   = '0;
               rgrp_in  = '0;
               rtype_in = bgp_pkg::KIND_EMPTY;
               rstat_in = bgp_pkg::ST_DONE;
               case (q_cmd.opcode)
                  bgp_pkg::OP_START: begin
                     cur_in    = '0;
                     pc_in     = '0;
                     pkind_in  = q_cmd.pass_is_host;
                     rvalid_in = 1'b1;
                  end
                  bgp_pkg::OP_ADD: state_in = S_ADD_RD;
                  bgp_pkg::OP_XLATE: begin
                     if (cfg.block_size == '0 || gsum == '0) begin
                        rid_in    = q_cmd.order_id;
                        rvalid_in = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV1;
                     end
                  end
                  default: rvalid_in = 1'b1;
               endcase
            end
         end
         S_ADD_RD: state_in = S_ADD_EX;
         S_ADD_EX: begin
            rgrp_in   = 8'(16'(cur_ff));
            rtype_in  = g_ok ? kind : bgp_pkg::KIND_EMPTY;
            rvalid_in = 1'b1;
            state_in  = S_IDLE;
            if (!cmd_ff.block_present || (cmd_ff.block_is_host != pkind_ff)) begin
               rstat_in = bgp_pkg::ST_SKIP;
            end else if (16'(cur_ff) >= 16'(cfg.group_count) || !g_ok ||
                         {1'b0, fill} >= (FW + 1)'(MAX_BLOCKS_PER_GROUP)) begin
               rstat_in = bgp_pkg::ST_OVERFLOW;
            end else begin
               tbl_we                     = 1'b1;
               meta_we                    = 1'b1;
               valid_in[cur_ff[GA_W-1:0]] = 1'b1;
               rtype_in                   = nk;
               pc_in                      = FW'(pc_ff + FW'(1));
               if (close) begin
                  cur_in = CUR_W'(cur_ff + CUR_W'(1));
                  pc_in  = '0;
               end
            end
         end
         S_DIV1: begin
            if (div_done) begin
               off_in    = div_rem;
               div_start = 1'b1;
               state_in  = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               grp_in   = div_quo;
               slot_in  = div_rem[7:0];
               state_in = S_XL_CHK;
            end
         end
         S_XL_CHK: begin
            if (grp_ff >= 40'(cfg.group_count) || grp_ff >= 40'(MAX_GROUPS)) begin
               rid_in    = cmd_ff.order_id;
               rvalid_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_XL_FILL;
            end
         end
         S_XL_FILL: begin
            if (10'(slot_ff) >= 10'(fill)) begin
               rid_in    = cmd_ff.order_id;
               rvalid_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_XL_TBL;
            end
         end
         S_XL_TBL: begin
            prod_in  = 41'(tbl_rdata) * 41'(cfg.block_size);
            state_in = S_XL_SUM;
         end
         S_XL_SUM: begin
            rid_in    = 40'(prod_ff + 41'(off_ff));
            rvalid_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cur_ff    <= '0;
         pc_ff     <= '0;
         pkind_ff  <= 1'b0;
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cur_ff    <= cur_in;
         pc_ff     <= pc_in;
         pkind_ff  <= pkind_in;
         valid_ff  <= valid_in;
         rvalid_ff <= rvalid_in;
      end
      mvld_ff  <= valid_ff[meta_raddr];
      cmd_ff   <= cmd_in;
      off_ff   <= off_in;
      grp_ff   <= grp_in;
      slot_ff  <= slot_in;
      prod_ff  <= prod_in;
      rid_ff   <= rid_in;
      rgrp_ff  <= rgrp_in;
      rtype_ff <= rtype_in;
      rstat_ff <= rstat_in;
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_index_id    = rid_ff;
   assign rsp_group_index = rgrp_ff;
   assign rsp_group_type  = rtype_ff;
   assign rsp_status      = rstat_ff;

endmodule

FILE: src/block_group_packer_and_id_remapper.sv
// Packs storage blocks into search groups and maps search order ids back to
// index ids.
// Request channel (req_*): valid/stall; one transaction carries an opcode:
// start pass, add block or translate order id. Response channel (rsp_*):
// exactly one response per request, in request order.
// Configuration (csr_*): block size, per-pass group limits and group count,
// written with csr_write while no request is outstanding.
// Start pass and unknown opcodes answer from the idle state straight into
// the response register; add block first passes S_ADD_RD and S_ADD_EX.
// A full translate runs two 40-step passes of one shared radix-2 divider (id
// by block size, then by blocks per group), a fill lookup, a table read and
// a multiply. Sequential: the back end works on one request at a time.
// A two-entry request queue keeps accepting while the back end is busy or
// the response waits; req_stall rises when that queue is full.
// When rsp_stall is high the response register holds and the back end
// waits before starting the next request.
// Reset clears the queue, pass cursor and all group fills and types at
// once (valid bits); block table contents stay undefined until written.
module block_group_packer_and_id_remapper #(
   parameter int MAX_GROUPS = 256,
   parameter int MAX_BLOCKS_PER_GROUP = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic        req_pass_is_host,
   input  logic [23:0] req_block_id,
   input  logic        req_block_present,
   input  logic        req_block_is_host,
   input  logic [39:0] req_order_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [39:0] rsp_index_id,
   output logic [7:0]  rsp_group_index,
   output logic [1:0]  rsp_group_type,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   bgp_pkg::cfg_type cfg_ff;
   bgp_pkg::cmd_type q_cmd;
   logic             q_valid, q_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size  <= 17'd16384;
         cfg_ff.dev_blocks  <= 7'd8;
         cfg_ff.host_blocks <= 7'd8;
         cfg_ff.group_count <= 9'd0;
      end else if (csr_write) begin
         case (csr_index)
            bgp_pkg::REG_BLOCK_SIZE:  cfg_ff.block_size  <= csr_wdata;
            bgp_pkg::REG_DEV_BLOCKS:  cfg_ff.dev_blocks  <= csr_wdata[6:0];
            bgp_pkg::REG_HOST_BLOCKS: cfg_ff.host_blocks <= csr_wdata[6:0];
            bgp_pkg::REG_GROUP_COUNT: cfg_ff.group_count <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   bgp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pass_is_host  (req_pass_is_host),
      .req_block_id      (req_block_id),
      .req_block_present (req_block_present),
      .req_block_is_host (req_block_is_host),
      .req_order_id      (req_order_id),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_pop             (q_pop)
   );

   bgp_back #(
      .MAX_GROUPS           (MAX_GROUPS),
      .MAX_BLOCKS_PER_GROUP (MAX_BLOCKS_PER_GROUP)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_index_id    (rsp_index_id),
      .rsp_group_index (rsp_group_index),
      .rsp_group_type  (rsp_group_type),
      .rsp_status      (rsp_status)
   );

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // skipped or overflowing adds never carry a translated id
   a_status_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bgp_pkg::ST_DONE |-> rsp_index_id == 40'd0)
      else $error("index id on a failed add");

   // a translated id comes with no group fields
   a_id_no_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_id != 40'd0 |->
         rsp_group_index == 8'd0 && rsp_group_type == bgp_pkg::KIND_EMPTY &&
         rsp_status == bgp_pkg::ST_DONE)
      else $error("group fields on a translate response");

   // the queue never pops when empty
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule
